// ===== rtl/assert_macros.svh =====
// assertion macros used by the rtl sequencer
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that holds in the same cycle
`define IIA_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// antecedent in one cycle, consequent in the next
`define IIA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/iia_pkg.sv =====
// types, constants and codes of the interval id allocator
package iia_pkg;

  localparam int ID_W       = 16;
  localparam int MAX_RANGES = 32;
  localparam int ADDR_W     = $clog2(MAX_RANGES);
  localparam int CNT_W      = $clog2(MAX_RANGES + 1);

  localparam logic [ID_W-1:0] ID_MASK  = {ID_W{1'b1}};
  localparam logic [ID_W-1:0] ID_ZERO  = '0;
  localparam logic [ID_W-1:0] ID_ONE   = ID_W'(1);
  localparam logic [ID_W:0]   EMPTY_MARK = {1'b1, {ID_W{1'b0}}};
  localparam logic [CNT_W-1:0] RANGES_MAX = CNT_W'(MAX_RANGES);

  localparam logic ACT_ALLOC   = 1'b0;
  localparam logic ACT_RELEASE = 1'b1;

  localparam logic [1:0] STATUS_OK         = 2'd0;
  localparam logic [1:0] STATUS_EXHAUSTED  = 2'd1;
  localparam logic [1:0] STATUS_TABLE_FULL = 2'd2;

  typedef struct packed {
    logic            action;
    logic [ID_W-1:0] release_id;
  } in_t;

  typedef struct packed {
    logic [ID_W-1:0] allocated_id;
    logic [1:0]      status;
  } out_t;

  typedef struct packed {
    logic [ID_W-1:0] start;
    logic [ID_W-1:0] count;
  } entry_t;

  typedef struct packed {
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    entry_t            wr_data;
  } tbl_req_t;

  typedef struct packed {
    logic [ID_W:0] a;
    logic [ID_W:0] b;
    logic          cin;
    logic [ID_W:0] c;
  } alu_req_t;

  typedef struct packed {
    logic [ID_W:0] sum;
    logic          lt;
    logic          eq;
  } alu_rsp_t;

  typedef enum logic [3:0] {
    S_INIT,
    S_IDLE,
    S_AL_S,
    S_AL_C,
    S_SC_RD,
    S_SC_CMP,
    S_D_PREV,
    S_D_NXT,
    S_D_WR,
    S_SHD_RD,
    S_SHD_WR,
    S_SHU_RD,
    S_SHU_WR,
    S_INS,
    S_FIN
  } state_t;

endpackage

// ===== rtl/iia_table.sv =====
// free range table: one write port, one registered read port
module iia_table (
  input  logic              clk,
  input  iia_pkg::tbl_req_t req,
  output iia_pkg::entry_t   rd_data
);

  iia_pkg::entry_t mem [iia_pkg::MAX_RANGES];

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
    if (req.rd_en) begin
      rd_data <= mem[req.rd_addr];
    end
  end

endmodule

// ===== rtl/iia_alu.sv =====
// shared adder with compare of the sum against a third operand
module iia_alu (
  input  iia_pkg::alu_req_t req,
  output iia_pkg::alu_rsp_t rsp
);

  logic [iia_pkg::ID_W:0] sum;

  assign sum     = req.a + req.b + {{iia_pkg::ID_W{1'b0}}, req.cin};
  assign rsp.sum = sum;
  assign rsp.lt  = sum < req.c;
  assign rsp.eq  = sum == req.c;

endmodule

// ===== rtl/iia_seq.sv =====
// sequencer: allocates from the first range, and scans, joins, inserts and shifts the range table one step at a time
`include "assert_macros.svh"

module iia_seq (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  iia_pkg::in_t      in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output iia_pkg::out_t     out_data,
  output iia_pkg::tbl_req_t tbl_req,
  input  iia_pkg::entry_t   tbl_rd_data,
  output iia_pkg::alu_req_t alu_req,
  input  iia_pkg::alu_rsp_t alu_rsp
);

  iia_pkg::state_t state_r, state_nxt;
  logic [iia_pkg::CNT_W-1:0] ranges_r, ranges_nxt;
  logic [iia_pkg::CNT_W-1:0] pos_r, pos_nxt;
  logic [iia_pkg::CNT_W-1:0] idx_r, idx_nxt;
  iia_pkg::in_t    item_r, item_nxt;
  iia_pkg::entry_t prev_r, prev_nxt;
  iia_pkg::entry_t next_r, next_nxt;
  logic            has_next_r, has_next_nxt;
  logic            jp_r, jp_nxt;
  logic            jn_r, jn_nxt;
  logic [iia_pkg::ID_W-1:0] tmp_start_r, tmp_start_nxt;
  iia_pkg::out_t   res_r, res_nxt;
  iia_pkg::out_t   out_r, out_nxt;
  logic            out_valid_r, out_valid_nxt;

  logic [iia_pkg::CNT_W-1:0] idx_inc, idx_dec, pos_dec;
  logic has_prev, jn, load_out;

  assign idx_inc  = idx_r + iia_pkg::CNT_W'(1);
  assign idx_dec  = idx_r - iia_pkg::CNT_W'(1);
  assign pos_dec  = pos_r - iia_pkg::CNT_W'(1);
  assign has_prev = pos_r != '0;
  assign jn       = has_next_r && alu_rsp.eq;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= iia_pkg::S_INIT;
      ranges_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      ranges_r    <= ranges_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pos_r       <= pos_nxt;
    idx_r       <= idx_nxt;
    item_r      <= item_nxt;
    prev_r      <= prev_nxt;
    next_r      <= next_nxt;
    has_next_r  <= has_next_nxt;
    jp_r        <= jp_nxt;
    jn_r        <= jn_nxt;
    tmp_start_r <= tmp_start_nxt;
    res_r       <= res_nxt;
    out_r       <= out_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    ranges_nxt    = ranges_r;
    pos_nxt       = pos_r;
    idx_nxt       = idx_r;
    item_nxt      = item_r;
    prev_nxt      = prev_r;
    next_nxt      = next_r;
    has_next_nxt  = has_next_r;
    jp_nxt        = jp_r;
    jn_nxt        = jn_r;
    tmp_start_nxt = tmp_start_r;
    res_nxt       = res_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && !out_ready;
    in_ready      = 1'b0;
    load_out      = 1'b0;
    tbl_req       = '0;
    alu_req       = '0;

    unique case (state_r)
      iia_pkg::S_INIT: begin
        tbl_req.wr_en         = 1'b1;
        tbl_req.wr_addr       = '0;
        tbl_req.wr_data.start = iia_pkg::ID_ONE;
        tbl_req.wr_data.count = iia_pkg::ID_MASK - iia_pkg::ID_ONE;
        ranges_nxt            = iia_pkg::CNT_W'(1);
        state_nxt             = iia_pkg::S_IDLE;
      end
      iia_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          item_nxt             = in_data;
          res_nxt.allocated_id = iia_pkg::ID_ZERO;
          res_nxt.status       = iia_pkg::STATUS_OK;
          if (in_data.action == iia_pkg::ACT_ALLOC) begin
            if (ranges_r == '0) begin
              res_nxt.status = iia_pkg::STATUS_EXHAUSTED;
              state_nxt      = iia_pkg::S_FIN;
            end else begin
              tbl_req.rd_en   = 1'b1;
              tbl_req.rd_addr = '0;
              state_nxt       = iia_pkg::S_AL_S;
            end
          end else if (in_data.release_id == iia_pkg::ID_ZERO ||
                       in_data.release_id == iia_pkg::ID_MASK) begin
            state_nxt = iia_pkg::S_FIN;
          end else begin
            pos_nxt   = '0;
            state_nxt = iia_pkg::S_SC_RD;
          end
        end
      end
      iia_pkg::S_AL_S: begin
        alu_req.a            = {1'b0, tbl_rd_data.start};
        alu_req.cin          = 1'b1;
        tmp_start_nxt        = alu_rsp.sum[iia_pkg::ID_W-1:0];
        res_nxt.allocated_id = tbl_rd_data.start;
        state_nxt            = iia_pkg::S_AL_C;
      end
      iia_pkg::S_AL_C: begin
        // count minus one, with the emptied range seen as a carry out alone
        alu_req.a = {1'b0, tbl_rd_data.count};
        alu_req.b = {1'b0, iia_pkg::ID_MASK};
        alu_req.c = iia_pkg::EMPTY_MARK;
        if (alu_rsp.eq) begin
          idx_nxt   = '0;
          state_nxt = iia_pkg::S_SHD_RD;
        end else begin
          tbl_req.wr_en         = 1'b1;
          tbl_req.wr_addr       = '0;
          tbl_req.wr_data.start = tmp_start_r;
          tbl_req.wr_data.count = alu_rsp.sum[iia_pkg::ID_W-1:0];
          state_nxt             = iia_pkg::S_FIN;
        end
      end
      iia_pkg::S_SC_RD: begin
        if (pos_r == ranges_r) begin
          has_next_nxt = 1'b0;
          state_nxt    = iia_pkg::S_D_PREV;
        end else begin
          tbl_req.rd_en   = 1'b1;
          tbl_req.rd_addr = pos_r[iia_pkg::ADDR_W-1:0];
          state_nxt       = iia_pkg::S_SC_CMP;
        end
      end
      iia_pkg::S_SC_CMP: begin
        alu_req.a = {1'b0, tbl_rd_data.start};
        alu_req.c = {1'b0, item_r.release_id};
        if (alu_rsp.lt) begin
          prev_nxt  = tbl_rd_data;
          pos_nxt   = pos_r + iia_pkg::CNT_W'(1);
          state_nxt = iia_pkg::S_SC_RD;
        end else if (alu_rsp.eq) begin
          // already the start of a free range
          state_nxt = iia_pkg::S_FIN;
        end else begin
          next_nxt     = tbl_rd_data;
          has_next_nxt = 1'b1;
          state_nxt    = iia_pkg::S_D_PREV;
        end
      end
      iia_pkg::S_D_PREV: begin
        alu_req.a = {1'b0, prev_r.start};
        alu_req.b = {1'b0, prev_r.count};
        alu_req.c = {1'b0, item_r.release_id};
        jp_nxt    = has_prev && alu_rsp.eq;
        if (has_prev && !alu_rsp.lt && !alu_rsp.eq) begin
          // inside the range below
          state_nxt = iia_pkg::S_FIN;
        end else begin
          state_nxt = iia_pkg::S_D_NXT;
        end
      end
      iia_pkg::S_D_NXT: begin
        alu_req.a   = {1'b0, item_r.release_id};
        alu_req.cin = 1'b1;
        alu_req.c   = {1'b0, next_r.start};
        jn_nxt      = jn;
        if (jp_r || jn) begin
          state_nxt = iia_pkg::S_D_WR;
        end else if (ranges_r >= iia_pkg::RANGES_MAX) begin
          res_nxt.status = iia_pkg::STATUS_TABLE_FULL;
          state_nxt      = iia_pkg::S_FIN;
        end else begin
          idx_nxt   = ranges_r;
          state_nxt = iia_pkg::S_SHU_RD;
        end
      end
      iia_pkg::S_D_WR: begin
        alu_req.a     = {1'b0, jp_r ? prev_r.count : next_r.count};
        alu_req.b     = {1'b0, (jp_r && jn_r) ? next_r.count : iia_pkg::ID_ZERO};
        alu_req.cin   = 1'b1;
        tbl_req.wr_en = 1'b1;
        tbl_req.wr_addr       = jp_r ? pos_dec[iia_pkg::ADDR_W-1:0]
                                     : pos_r[iia_pkg::ADDR_W-1:0];
        tbl_req.wr_data.start = jp_r ? prev_r.start : item_r.release_id;
        tbl_req.wr_data.count = alu_rsp.sum[iia_pkg::ID_W-1:0];
        if (jp_r && jn_r) begin
          idx_nxt   = pos_r;
          state_nxt = iia_pkg::S_SHD_RD;
        end else begin
          state_nxt = iia_pkg::S_FIN;
        end
      end
      iia_pkg::S_SHD_RD: begin
        if (idx_inc < ranges_r) begin
          tbl_req.rd_en   = 1'b1;
          tbl_req.rd_addr = idx_inc[iia_pkg::ADDR_W-1:0];
          state_nxt       = iia_pkg::S_SHD_WR;
        end else begin
          ranges_nxt = ranges_r - iia_pkg::CNT_W'(1);
          state_nxt  = iia_pkg::S_FIN;
        end
      end
      iia_pkg::S_SHD_WR: begin
        tbl_req.wr_en   = 1'b1;
        tbl_req.wr_addr = idx_r[iia_pkg::ADDR_W-1:0];
        tbl_req.wr_data = tbl_rd_data;
        idx_nxt         = idx_inc;
        state_nxt       = iia_pkg::S_SHD_RD;
      end
      iia_pkg::S_SHU_RD: begin
        if (idx_r > pos_r) begin
          tbl_req.rd_en   = 1'b1;
          tbl_req.rd_addr = idx_dec[iia_pkg::ADDR_W-1:0];
          state_nxt       = iia_pkg::S_SHU_WR;
        end else begin
          state_nxt = iia_pkg::S_INS;
        end
      end
      iia_pkg::S_SHU_WR: begin
        tbl_req.wr_en   = 1'b1;
        tbl_req.wr_addr = idx_r[iia_pkg::ADDR_W-1:0];
        tbl_req.wr_data = tbl_rd_data;
        idx_nxt         = idx_dec;
        state_nxt       = iia_pkg::S_SHU_RD;
      end
      iia_pkg::S_INS: begin
        tbl_req.wr_en         = 1'b1;
        tbl_req.wr_addr       = pos_r[iia_pkg::ADDR_W-1:0];
        tbl_req.wr_data.start = item_r.release_id;
        tbl_req.wr_data.count = iia_pkg::ID_ONE;
        ranges_nxt            = ranges_r + iia_pkg::CNT_W'(1);
        state_nxt             = iia_pkg::S_FIN;
      end
      iia_pkg::S_FIN: begin
        if (!out_valid_r || out_ready) begin
          load_out      = 1'b1;
          out_nxt       = res_r;
          out_valid_nxt = 1'b1;
          state_nxt     = iia_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = iia_pkg::S_IDLE;
      end
    endcase
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  `IIA_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, in_valid && in_ready, !in_ready,
                   "input taken again while an item is at work")
  `IIA_ASSERT(a_exhausted_only_empty, clk, rst_n,
              !(load_out && res_r.status == iia_pkg::STATUS_EXHAUSTED) || ranges_r == '0,
              "exhausted reported with ranges left")
  `IIA_ASSERT(a_full_only_when_full, clk, rst_n,
              !(load_out && res_r.status == iia_pkg::STATUS_TABLE_FULL) ||
              ranges_r == iia_pkg::RANGES_MAX,
              "table full reported with a free slot")

endmodule

// ===== rtl/interval_id_allocator_core.sv =====
// top level of the interval id allocator
//
// usage
// - in channel: valid/ready, one transfer carries an action (allocate or
//   release) and the identifier being released
// - out channel: valid/ready, one transfer per input item with the
//   allocated identifier and a status (ok, exhausted, table full)
// - allocate reads the first range, takes its start and writes the range
//   back one shorter; when the first range empties, the ranges behind it
//   are moved down one place instead
// - release scans the sorted free ranges below the identifier, then checks
//   the neighbours below and above and decides; a join rewrites one entry,
//   an insertion moves the entries above up and a merge of both
//   neighbours moves the entries above down
// - the steps are set by the single table read port (registered read)
//   and the one shared adder and comparator, each used once per step
// - one item at a time: in_ready is high only while the sequencer idles
// - after reset the init state writes the initial range (1 .. all-ones - 1)
//   before the first item is taken
// - a result sits in an output register; if the receiver stalls, the next
//   item is still taken and worked on, and waits only at its own finish
module interval_id_allocator_core (
  input  logic          clk,
  input  logic          rst_n,
  // input channel
  input  logic          in_valid,
  output logic          in_ready,
  input  iia_pkg::in_t  in_data,
  // result channel
  output logic          out_valid,
  input  logic          out_ready,
  output iia_pkg::out_t out_data
);

  // table port and shared unit links
  iia_pkg::tbl_req_t tbl_req;
  iia_pkg::entry_t   tbl_rd_data;
  iia_pkg::alu_req_t alu_req;
  iia_pkg::alu_rsp_t alu_rsp;

  // sorted free range table
  iia_table u_table (
    .clk     (clk),
    .req     (tbl_req),
    .rd_data (tbl_rd_data)
  );

  // shared add and compare unit
  iia_alu u_alu (
    .req (alu_req),
    .rsp (alu_rsp)
  );

  // step sequencer with result register
  iia_seq u_seq (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_data    (out_data),
    .tbl_req     (tbl_req),
    .tbl_rd_data (tbl_rd_data),
    .alu_req     (alu_req),
    .alu_rsp     (alu_rsp)
  );

endmodule
